FILE: sv/pls_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the positional list store.
// No dependencies; every other file in the block uses this package.
package pls_pkg;

  localparam int unsigned CNT_W  = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] REQ_READ   = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [CNT_W-1:0]         position;
    logic signed [DATA_W-1:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] found_value;
    logic [CNT_W-1:0]         length_now;
  } out_item_t;

  typedef struct packed {
    logic              wr_en;
    logic [CNT_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [CNT_W-1:0]  rd_addr;
  } mem_cmd_t;

endpackage

FILE: sv/pls_mem.sv
`timescale 1ns / 1ps
// Element storage: one write port and one read port with registered read data.
// Depends on pls_pkg for the command struct and widths.
module pls_mem #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                           clk,
  input  pls_pkg::mem_cmd_t              cmd,
  output logic [pls_pkg::DATA_W-1:0]     rd_data
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [pls_pkg::DATA_W-1:0] mem [DEPTH];
  logic [pls_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr[IW-1:0]] <= cmd.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr[IW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/pls_seq.sv
`timescale 1ns / 1ps
// Request sequencer: checks the position, then moves elements one at a time
// through the memory port to open or close a gap. Depends on pls_pkg.
module pls_seq #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  pls_pkg::in_item_t              in_data,
  output logic                           in_stall,
  output pls_pkg::mem_cmd_t              mem_cmd,
  input  logic [pls_pkg::DATA_W-1:0]     mem_rd_data,
  output logic                           res_valid,
  output pls_pkg::out_item_t             res_data,
  input  logic                           res_take
);

  localparam int unsigned CW = pls_pkg::CNT_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CAP   = 5'b00010,
    S_SHIFT = 5'b00100,
    S_MOVE  = 5'b01000,
    S_DONE  = 5'b10000
  } seq_state_t;

  seq_state_t                 st_r, st_nxt;
  logic [1:0]                 op_r, op_nxt;
  logic [CW-1:0]              pidx_r, pidx_nxt;
  logic [pls_pkg::DATA_W-1:0] val_r, val_nxt;
  logic [CW-1:0]              k_r, k_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [1:0]                 status_r, status_nxt;
  logic [pls_pkg::DATA_W-1:0] found_r, found_nxt;

  logic          pos_nz;
  logic          pos_in_list;
  logic          pos_in_gap;
  logic          is_full;
  logic [CW:0]   k_next_ext;

  assign pos_nz      = (in_data.position != '0);
  assign pos_in_list = pos_nz && (in_data.position <= count_r);
  assign pos_in_gap  = pos_nz && ({1'b0, in_data.position} <= ({1'b0, count_r} + (CW+1)'(1)));
  assign is_full     = (count_r == CW'(DEPTH));
  assign k_next_ext  = {1'b0, k_r} + (CW+1)'(1);

  always_comb begin
    st_nxt     = st_r;
    op_nxt     = op_r;
    pidx_nxt   = pidx_r;
    val_nxt    = val_r;
    k_nxt      = k_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    mem_cmd    = '0;

    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_data.req_type;
          pidx_nxt   = in_data.position - CW'(1);
          val_nxt    = in_data.new_value;
          found_nxt  = '0;
          status_nxt = pls_pkg::ST_RANGE;
          st_nxt     = S_DONE;
          unique case (in_data.req_type)
            pls_pkg::REQ_READ, pls_pkg::REQ_DELETE: begin
              if (pos_in_list) begin
                mem_cmd.rd_en   = 1'b1;
                mem_cmd.rd_addr = in_data.position - CW'(1);
                status_nxt      = pls_pkg::ST_OK;
                st_nxt          = S_CAP;
              end
            end
            pls_pkg::REQ_INSERT: begin
              if (pos_in_gap) begin
                if (is_full) begin
                  status_nxt = pls_pkg::ST_FULL;
                end else begin
                  k_nxt      = count_r;
                  status_nxt = pls_pkg::ST_OK;
                  st_nxt     = S_SHIFT;
                end
              end
            end
            default: begin
              status_nxt = pls_pkg::ST_RANGE;
            end
          endcase
        end
      end
      S_CAP: begin
        found_nxt = mem_rd_data;
        if (op_r == pls_pkg::REQ_DELETE) begin
          k_nxt  = pidx_r;
          st_nxt = S_SHIFT;
        end else begin
          st_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        if (op_r == pls_pkg::REQ_INSERT) begin
          if (k_r > pidx_r) begin
            mem_cmd.rd_en   = 1'b1;
            mem_cmd.rd_addr = k_r - CW'(1);
            st_nxt          = S_MOVE;
          end else begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = pidx_r;
            mem_cmd.wr_data = val_r;
            count_nxt       = count_r + CW'(1);
            st_nxt          = S_DONE;
          end
        end else begin
          if (k_next_ext < {1'b0, count_r}) begin
            mem_cmd.rd_en   = 1'b1;
            mem_cmd.rd_addr = k_next_ext[CW-1:0];
            st_nxt          = S_MOVE;
          end else begin
            count_nxt = count_r - CW'(1);
            st_nxt    = S_DONE;
          end
        end
      end
      S_MOVE: begin
        mem_cmd.wr_en   = 1'b1;
        mem_cmd.wr_addr = k_r;
        mem_cmd.wr_data = mem_rd_data;
        k_nxt           = (op_r == pls_pkg::REQ_INSERT) ? (k_r - CW'(1)) : k_next_ext[CW-1:0];
        st_nxt          = S_SHIFT;
      end
      S_DONE: begin
        if (res_take) begin
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      count_r <= '0;
    end else begin
      st_r    <= st_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    pidx_r   <= pidx_nxt;
    val_r    <= val_nxt;
    k_r      <= k_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
  end

  assign in_stall             = (st_r != S_IDLE);
  assign res_valid            = (st_r == S_DONE);
  assign res_data.status      = status_r;
  assign res_data.found_value = found_r;
  assign res_data.length_now  = count_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count exceeds depth");

  a_wr_addr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mem_cmd.wr_en |-> (mem_cmd.wr_addr < CW'(DEPTH)))
    else $error("memory write beyond depth");

  a_no_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE || st_r == S_DONE) |-> !mem_cmd.wr_en)
    else $error("memory written outside a request");

  a_read_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE && in_valid && in_data.req_type == pls_pkg::REQ_READ) |=>
      $stable(count_r))
    else $error("read request changed the count");
`endif

endmodule

FILE: sv/positional_list_store.sv
`timescale 1ns / 1ps
// Positional list store: ordered list of signed words with read, insert and delete.
// Each request is handled on its own: the next request beat is taken the cycle after
// the response is loaded into the output register, which waits while out_stall holds it.
// Each moved element costs a memory read in S_SHIFT and a memory write in S_MOVE.
// Synchronous active-low reset empties the list; stored words are not cleared.
module positional_list_store #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  pls_pkg::in_item_t   in_data,
  output logic                in_stall,
  output logic                out_valid,
  output pls_pkg::out_item_t  out_data,
  input  logic                out_stall
);

  pls_pkg::mem_cmd_t          mem_cmd;
  logic [pls_pkg::DATA_W-1:0] mem_rd_data;
  logic                       res_valid;
  pls_pkg::out_item_t         res_data;
  logic                       res_take;

  logic                       out_valid_r, out_valid_nxt;
  pls_pkg::out_item_t         out_data_r;

  pls_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .cmd     (mem_cmd),
    .rd_data (mem_rd_data)
  );

  pls_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .in_stall    (in_stall),
    .mem_cmd     (mem_cmd),
    .mem_rd_data (mem_rd_data),
    .res_valid   (res_valid),
    .res_data    (res_data),
    .res_take    (res_take)
  );

  // The output register takes a new beat when empty or when its beat drains.
  assign res_take      = res_valid && (!out_valid_r || !out_stall);
  assign out_valid_nxt = res_take || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: test/list_checker.sv
`timescale 1ns / 1ps
// Checker for the positional list store: watches both channels, predicts each response
// from its own copy of the list and compares every response beat field by field.
// Depends on pls_pkg for the beat types, request codes and status codes.
module list_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  pls_pkg::in_item_t  in_data,
  input  logic               in_stall,
  input  logic               out_valid,
  input  pls_pkg::out_item_t out_data,
  input  logic               out_stall,
  output int unsigned        fail_count,
  output int unsigned        pending_count
);

  logic signed [pls_pkg::DATA_W-1:0] list_words [DEPTH];
  logic [pls_pkg::CNT_W-1:0]         list_len;
  pls_pkg::out_item_t                expected_q [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    list_len      = '0;
  end

  function automatic pls_pkg::out_item_t apply_request(input pls_pkg::in_item_t req);
    pls_pkg::out_item_t rsp;
    int                 pos;
    int                 len;
    int                 k;
    rsp.status      = pls_pkg::ST_RANGE;
    rsp.found_value = '0;
    pos = int'(req.position);
    len = int'(list_len);
    case (req.req_type)
      pls_pkg::REQ_READ: begin
        if (pos >= 1 && pos <= len) begin
          rsp.found_value = list_words[pos-1];
          rsp.status      = pls_pkg::ST_OK;
        end
      end
      pls_pkg::REQ_INSERT: begin
        if (pos >= 1 && pos <= len + 1) begin
          if (len >= DEPTH) begin
            rsp.status = pls_pkg::ST_FULL;
          end else begin
            for (k = len; k > pos - 1; k--) begin
              list_words[k] = list_words[k-1];
            end
            list_words[pos-1] = req.new_value;
            len++;
            rsp.status = pls_pkg::ST_OK;
          end
        end
      end
      pls_pkg::REQ_DELETE: begin
        if (pos >= 1 && pos <= len) begin
          rsp.found_value = list_words[pos-1];
          for (k = pos - 1; k + 1 < len; k++) begin
            list_words[k] = list_words[k+1];
          end
          len--;
          rsp.status = pls_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
    list_len       = len[pls_pkg::CNT_W-1:0];
    rsp.length_now = list_len;
    return rsp;
  endfunction

  task automatic log_failure(input string what);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t ns: %s", $realtime, what);
    end
  endtask

  always @(posedge clk) begin : watch
    pls_pkg::out_item_t want;
    if (!rst_n) begin
      list_len = '0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          log_failure($sformatf("response beat with nothing expected: status %0d value %0d len %0d",
                                out_data.status, out_data.found_value, out_data.length_now));
        end else begin
          want = expected_q.pop_front();
          if (out_data.status !== want.status || out_data.found_value !== want.found_value ||
              out_data.length_now !== want.length_now) begin
            log_failure($sformatf("expected status %0d value %0d len %0d, got %0d %0d %0d",
                                  want.status, want.found_value, want.length_now,
                                  out_data.status, out_data.found_value, out_data.length_now));
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_q.push_back(apply_request(in_data));
      end
    end
    pending_count = expected_q.size();
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Top of the positional list store test: clock, reset, request and stall stimulus, verdict.
// Depends on pls_pkg, positional_list_store and list_checker.
module testbench;

  localparam int unsigned LIST_DEPTH   = 16;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned QUIET_ITEMS  = 150;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned POS_W        = pls_pkg::CNT_W;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;

  localparam logic signed [pls_pkg::DATA_W-1:0] VAL_MIN = {1'b1, {(pls_pkg::DATA_W-1){1'b0}}};
  localparam logic signed [pls_pkg::DATA_W-1:0] VAL_MAX = {1'b0, {(pls_pkg::DATA_W-1){1'b1}}};

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  pls_pkg::in_item_t  in_data;
  logic               in_stall;
  logic               out_valid;
  pls_pkg::out_item_t out_data;
  logic               out_stall;
  int unsigned        fail_count;
  int unsigned        pending_count;
  int unsigned        cycle_count = 0;
  bit                 quiet_tail = 1'b0;
  int                 shadow_len = 0;

  always #5 clk = ~clk;

  positional_list_store #(
    .DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_stall(out_stall)
  );

  list_checker #(
    .DEPTH(LIST_DEPTH)
  ) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data      (in_data),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .out_stall    (out_stall),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic pls_pkg::in_item_t make_req(input logic [1:0] kind, input int pos,
                                                 input logic signed [pls_pkg::DATA_W-1:0] val);
    pls_pkg::in_item_t req;
    req.req_type  = kind;
    req.position  = pos[POS_W-1:0];
    req.new_value = val;
    return req;
  endfunction

  function automatic pls_pkg::in_item_t random_request(input int cur_len, input bit growing);
    pls_pkg::in_item_t req;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      req.req_type = 2'($urandom_range(0, 3));
      req.position = POS_W'($urandom_range(0, 31));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        req.req_type = pls_pkg::REQ_READ;
      end else if (pick < (growing ? 80 : 35)) begin
        req.req_type = pls_pkg::REQ_INSERT;
      end else begin
        req.req_type = pls_pkg::REQ_DELETE;
      end
      if (req.req_type == pls_pkg::REQ_INSERT) begin
        req.position = POS_W'($urandom_range(1, cur_len + 1));
      end else if (cur_len == 0) begin
        req.position = POS_W'(1);
      end else begin
        req.position = POS_W'($urandom_range(1, cur_len));
      end
    end
    case ($urandom_range(0, 7))
      0:       req.new_value = VAL_MIN;
      1:       req.new_value = VAL_MAX;
      2:       req.new_value = '0;
      default: req.new_value = $urandom;
    endcase
    return req;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_request(input pls_pkg::in_item_t req);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (req.req_type)
      pls_pkg::REQ_INSERT: begin
        if (req.position >= 1 && req.position <= shadow_len + 1 && shadow_len < LIST_DEPTH) begin
          shadow_len++;
        end
      end
      pls_pkg::REQ_DELETE: begin
        if (req.position >= 1 && req.position <= shadow_len) begin
          shadow_len--;
        end
      end
      default: begin
      end
    endcase
    @(negedge clk);
  endtask

  initial begin : stimulus
    bit growing;
    int phase_left;
    int n;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(make_req(pls_pkg::REQ_READ,   0,  VAL_MAX));
    send_request(make_req(pls_pkg::REQ_READ,   1,  VAL_MIN));
    send_request(make_req(pls_pkg::REQ_DELETE, 1,  '1));
    send_request(make_req(REQ_UNUSED,          1,  VAL_MAX));
    send_request(make_req(pls_pkg::REQ_INSERT, 0,  VAL_MAX));
    send_request(make_req(pls_pkg::REQ_INSERT, 2,  VAL_MAX));
    send_request(make_req(pls_pkg::REQ_INSERT, 1,  VAL_MIN));
    send_request(make_req(pls_pkg::REQ_INSERT, 2,  VAL_MAX));
    send_request(make_req(pls_pkg::REQ_INSERT, 1,  '1));
    send_request(make_req(pls_pkg::REQ_INSERT, 2,  '0));
    send_request(make_req(pls_pkg::REQ_READ,   1,  '0));
    send_request(make_req(pls_pkg::REQ_READ,   4,  '0));
    send_request(make_req(pls_pkg::REQ_READ,   5,  '0));
    send_request(make_req(pls_pkg::REQ_DELETE, 2,  '0));
    send_request(make_req(pls_pkg::REQ_DELETE, 3,  '0));
    send_request(make_req(pls_pkg::REQ_DELETE, 31, '0));
    send_request(make_req(pls_pkg::REQ_INSERT, 31, VAL_MIN));
    send_request(make_req(REQ_UNUSED,          31, '1));
    send_request(make_req(pls_pkg::REQ_READ,   2,  '1));

    growing    = 1'b1;
    phase_left = $urandom_range(40, 80);
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - QUIET_ITEMS) begin
        quiet_tail = 1'b1;
      end
      if (phase_left == 0) begin
        growing    = !growing;
        phase_left = $urandom_range(40, 80);
      end
      phase_left--;
      send_request(random_request(shadow_len, growing));
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
